FILE: design/ghst_pkg.sv
`timescale 1ns / 1ps

package ghst_pkg;

    localparam int SLOT_COUNT_DEF = 64;
    localparam int GEN_BITS_DEF   = 16;
    localparam int COUNT_BITS_DEF = 16;

    localparam int CMD_W       = 3;
    localparam int IN_INDEX_W  = 7;
    localparam int IN_GEN_W    = 16;
    localparam int IN_TDATA_W  = 24;

    localparam int STATUS_W    = 3;
    localparam int OUT_INDEX_W = 6;
    localparam int OUT_GEN_W   = 16;
    localparam int OUT_TDATA_W = 32;

    // width of one leaf group in the find-first-zero tree
    localparam int FFZ_GROUP = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC       = 3'd0,
        CMD_RELEASE     = 3'd1,
        CMD_ACQUIRE     = 3'd2,
        CMD_UNSUBSCRIBE = 3'd3,
        CMD_ALIVE_QUERY = 3'd4,
        CMD_GEN_QUERY   = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_BAD_INDEX = 3'd1,
        ST_STALE     = 3'd2,
        ST_NOT_OCC   = 3'd3,
        ST_IN_USE    = 3'd4,
        ST_UNDERFLOW = 3'd5,
        ST_FULL      = 3'd6,
        ST_OVERFLOW  = 3'd7
    } status_t;

endpackage

FILE: design/ghst_ram.sv
`timescale 1ns / 1ps

module ghst_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/ghst_ffz.sv
`timescale 1ns / 1ps

module ghst_ffz #(
    parameter int N = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [N-1:0]         occ,
    output logic                 found,
    output logic [$clog2(N)-1:0] index
);

    localparam int GW = ghst_pkg::FFZ_GROUP;
    localparam int NG = (N + GW - 1) / GW;
    localparam int LW = $clog2(GW);
    localparam int IW = $clog2(N);
    localparam int PW = NG * GW;

    logic [PW-1:0] padded;
    logic [NG-1:0] grp_any_reg;
    logic [NG-1:0] grp_any_next;
    logic [LW-1:0] grp_idx_reg  [NG];
    logic [LW-1:0] grp_idx_next [NG];

    // padding bits read as occupied
    always_comb
    begin
        padded = '1;
        padded[N-1:0] = occ;
    end

    always_comb
    begin
        for (int g = 0; g < NG; g++)
        begin
            grp_any_next[g] = 1'b0;
            grp_idx_next[g] = '0;
            for (int b = GW - 1; b >= 0; b--)
            begin
                if (!padded[g * GW + b])
                begin
                    grp_any_next[g] = 1'b1;
                    grp_idx_next[g] = LW'(b);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_any_reg <= '0;
            for (int g = 0; g < NG; g++)
            begin
                grp_idx_reg[g] <= '0;
            end
        end
        else
        begin
            grp_any_reg <= grp_any_next;
            for (int g = 0; g < NG; g++)
            begin
                grp_idx_reg[g] <= grp_idx_next[g];
            end
        end
    end

    always_comb
    begin
        found = 1'b0;
        index = '0;
        for (int g = NG - 1; g >= 0; g--)
        begin
            if (grp_any_reg[g])
            begin
                found = 1'b1;
                index = IW'(g * GW) + IW'(grp_idx_reg[g]);
            end
        end
    end

endmodule

FILE: design/generational_handle_slot_table_top.sv
`timescale 1ns / 1ps

// Generational handle slot table. Each command arrives as one transfer on the s_axis side
// (command in tuser, slot index and handle generation in tdata) and produces exactly one
// result transfer on the m_axis side. Generations and reference counts live in two
// single-port-write, registered-read RAMs; occupied bits and the slot counters are flops.
// Release, acquire, unsubscribe and the two queries pass through accept, then write-back (RAM
// read data is checked and the entry written back). Alloc adds a step in between for the
// registered find-first-zero tree over the occupied bits and the generation read of the
// slot it picks. A new command is taken once the previous one has written back; a result
// waiting on m_axis stalls the write-back of the next command until it is taken.
module generational_handle_slot_table_top #(
    parameter int SLOT_COUNT = ghst_pkg::SLOT_COUNT_DEF,
    parameter int GEN_BITS   = ghst_pkg::GEN_BITS_DEF,
    parameter int COUNT_BITS = ghst_pkg::COUNT_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // slot_index, handle_generation
    input  logic [ghst_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // cmd
    input  logic [ghst_pkg::CMD_W-1:0]       s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // status, out_index, out_generation, alive, all_free
    output logic [ghst_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int IDX_W  = $clog2(SLOT_COUNT);
    localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
    localparam int IIW    = ghst_pkg::IN_INDEX_W;
    localparam int IGW    = ghst_pkg::IN_GEN_W;
    localparam int CW     = ghst_pkg::CMD_W;
    localparam int SW     = ghst_pkg::STATUS_W;
    localparam int OIW    = ghst_pkg::OUT_INDEX_W;
    localparam int OGW    = ghst_pkg::OUT_GEN_W;
    localparam int ODW    = ghst_pkg::OUT_TDATA_W;
    localparam int CMP_W  = (CNT_W > IIW) ? CNT_W : IIW;
    localparam int GC_W   = (GEN_BITS > IGW) ? GEN_BITS : IGW;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FIND,
        S_EXEC
    } state_t;

    state_t            state_reg,  state_next;
    logic [CW-1:0]     cmd_reg,    cmd_next;
    logic [IIW-1:0]    idx_reg,    idx_next;
    logic [IGW-1:0]    hgen_reg,   hgen_next;
    logic [IDX_W-1:0]  alloc_idx_reg, alloc_idx_next;
    logic [SLOT_COUNT-1:0] occ_reg, occ_next;
    logic [CNT_W-1:0]  created_reg, created_next;
    logic [CNT_W-1:0]  total_reg,  total_next;
    logic              m_valid_reg, m_valid_next;
    logic [SW-1:0]     status_reg, status_next;
    logic [OIW-1:0]    oidx_reg,   oidx_next;
    logic [OGW-1:0]    ogen_reg,   ogen_next;
    logic              alive_reg,  alive_next;
    logic              all_free_reg, all_free_next;

    logic [IIW-1:0]    in_idx;
    logic [CW-1:0]     in_cmd;
    logic [IGW-1:0]    in_hgen;
    logic [IDX_W-1:0]  addr_reg;
    logic              go;

    logic              gen_re, cnt_re;
    logic [IDX_W-1:0]  rd_addr;
    logic              gen_we, cnt_we;
    logic [IDX_W-1:0]  wr_addr;
    logic [GEN_BITS-1:0]   gen_wd, gen_q, gen_inc;
    logic [COUNT_BITS-1:0] cnt_wd, cnt_q;

    logic              ffz_found;
    logic [IDX_W-1:0]  ffz_index;

    logic              known, match, occ_bit;
    logic              occ_set, occ_clr, total_inc, total_dec, created_inc;
    logic [SW-1:0]     res_status;
    logic [OIW-1:0]    res_index;
    logic [OGW-1:0]    res_gen;
    logic              res_alive;
    logic              do_write;

    assign in_idx  = s_axis_tdata[IIW-1:0];
    assign in_hgen = s_axis_tdata[IIW+IGW-1:IIW];
    assign in_cmd  = s_axis_tuser;

    assign addr_reg = IDX_W'(idx_reg);
    assign go       = !m_valid_reg || m_axis_tready;
    assign do_write = (state_reg == S_EXEC) && go;

    ghst_ffz #(
        .N (SLOT_COUNT)
    ) u_ffz (
        .clk   (clk),
        .rst_n (rst_n),
        .occ   (occ_reg),
        .found (ffz_found),
        .index (ffz_index)
    );

    ghst_ram #(
        .WIDTH (GEN_BITS),
        .DEPTH (SLOT_COUNT)
    ) u_gen_ram (
        .clk   (clk),
        .we    (do_write && gen_we),
        .waddr (wr_addr),
        .wdata (gen_wd),
        .re    (gen_re),
        .raddr (rd_addr),
        .rdata (gen_q)
    );

    ghst_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (SLOT_COUNT)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (do_write && cnt_we),
        .waddr (wr_addr),
        .wdata (cnt_wd),
        .re    (cnt_re),
        .raddr (rd_addr),
        .rdata (cnt_q)
    );

    assign gen_inc = gen_q + GEN_BITS'(1);
    assign known   = CMP_W'(idx_reg) < CMP_W'(created_reg);
    assign match   = GC_W'(gen_q) == GC_W'(hgen_reg);
    assign occ_bit = occ_reg[addr_reg];

    // command evaluation on the entry read back from the rams
    always_comb
    begin
        res_status  = ghst_pkg::ST_OK;
        res_index   = OIW'(idx_reg);
        res_gen     = '0;
        res_alive   = 1'b0;
        occ_set     = 1'b0;
        occ_clr     = 1'b0;
        total_inc   = 1'b0;
        total_dec   = 1'b0;
        created_inc = 1'b0;
        gen_we      = 1'b0;
        cnt_we      = 1'b0;
        gen_wd      = gen_q;
        cnt_wd      = cnt_q;
        wr_addr     = addr_reg;
        if (cmd_reg == ghst_pkg::CMD_ALLOC)
        begin
            if (total_reg == CNT_W'(SLOT_COUNT))
            begin
                res_status = ghst_pkg::ST_FULL;
            end
            else
            begin
                wr_addr   = alloc_idx_reg;
                cnt_we    = 1'b1;
                cnt_wd    = '0;
                occ_set   = 1'b1;
                total_inc = 1'b1;
                res_index = OIW'(alloc_idx_reg);
                res_alive = 1'b1;
                if (CNT_W'(alloc_idx_reg) == created_reg)
                begin
                    gen_we      = 1'b1;
                    gen_wd      = GEN_BITS'(1);
                    created_inc = 1'b1;
                    res_gen     = OGW'(GC_W'(GEN_BITS'(1)));
                end
                else
                begin
                    res_gen = OGW'(GC_W'(gen_q));
                end
            end
        end
        else if (cmd_reg > ghst_pkg::CMD_GEN_QUERY)
        begin
            res_status = ghst_pkg::ST_OK;
        end
        else if (!known)
        begin
            res_status = ghst_pkg::ST_BAD_INDEX;
        end
        else
        begin
            res_gen = OGW'(GC_W'(gen_q));
            if (cmd_reg == ghst_pkg::CMD_GEN_QUERY)
            begin
                res_alive = match && occ_bit;
            end
            else if (!match)
            begin
                res_status = ghst_pkg::ST_STALE;
            end
            else
            begin
                unique case (cmd_reg)
                    ghst_pkg::CMD_RELEASE:
                    begin
                        if (!occ_bit)
                        begin
                            res_status = ghst_pkg::ST_NOT_OCC;
                        end
                        else if (cnt_q != '0)
                        begin
                            res_status = ghst_pkg::ST_IN_USE;
                            res_alive  = 1'b1;
                        end
                        else
                        begin
                            occ_clr   = 1'b1;
                            total_dec = 1'b1;
                            gen_we    = 1'b1;
                            gen_wd    = gen_inc;
                            res_gen   = OGW'(GC_W'(gen_inc));
                        end
                    end
                    ghst_pkg::CMD_ACQUIRE:
                    begin
                        if (!occ_bit)
                        begin
                            res_status = ghst_pkg::ST_NOT_OCC;
                        end
                        else if (cnt_q == '1)
                        begin
                            res_status = ghst_pkg::ST_OVERFLOW;
                            res_alive  = 1'b1;
                        end
                        else
                        begin
                            cnt_we    = 1'b1;
                            cnt_wd    = cnt_q + COUNT_BITS'(1);
                            res_alive = 1'b1;
                        end
                    end
                    ghst_pkg::CMD_UNSUBSCRIBE:
                    begin
                        res_alive = occ_bit;
                        if (cnt_q == '0)
                        begin
                            res_status = ghst_pkg::ST_UNDERFLOW;
                        end
                        else
                        begin
                            cnt_we = 1'b1;
                            cnt_wd = cnt_q - COUNT_BITS'(1);
                        end
                    end
                    default:
                    begin
                        res_alive = occ_bit;
                    end
                endcase
            end
        end
    end

    // sequencing, read issue and state update
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        idx_next       = idx_reg;
        hgen_next      = hgen_reg;
        alloc_idx_next = alloc_idx_reg;
        occ_next       = occ_reg;
        created_next   = created_reg;
        total_next     = total_reg;
        m_valid_next   = m_valid_reg && !m_axis_tready;
        status_next    = status_reg;
        oidx_next      = oidx_reg;
        ogen_next      = ogen_reg;
        alive_next     = alive_reg;
        all_free_next  = all_free_reg;
        gen_re         = 1'b0;
        cnt_re         = 1'b0;
        rd_addr        = IDX_W'(in_idx);
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd_next  = in_cmd;
                    idx_next  = in_idx;
                    hgen_next = in_hgen;
                    if (in_cmd == ghst_pkg::CMD_ALLOC)
                    begin
                        state_next = S_FIND;
                    end
                    else
                    begin
                        gen_re     = 1'b1;
                        cnt_re     = 1'b1;
                        state_next = S_EXEC;
                    end
                end
            end
            S_FIND:
            begin
                rd_addr        = ffz_index;
                gen_re         = ffz_found;
                alloc_idx_next = ffz_index;
                state_next     = S_EXEC;
            end
            S_EXEC:
            begin
                if (go)
                begin
                    if (occ_set)
                    begin
                        occ_next[wr_addr] = 1'b1;
                    end
                    if (occ_clr)
                    begin
                        occ_next[wr_addr] = 1'b0;
                    end
                    if (created_inc)
                    begin
                        created_next = created_reg + CNT_W'(1);
                    end
                    if (total_inc)
                    begin
                        total_next = total_reg + CNT_W'(1);
                    end
                    else if (total_dec)
                    begin
                        total_next = total_reg - CNT_W'(1);
                    end
                    m_valid_next  = 1'b1;
                    status_next   = res_status;
                    oidx_next     = res_index;
                    ogen_next     = res_gen;
                    alive_next    = res_alive;
                    all_free_next = (total_next == '0);
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmd_reg       <= '0;
            idx_reg       <= '0;
            hgen_reg      <= '0;
            alloc_idx_reg <= '0;
            occ_reg       <= '0;
            created_reg   <= '0;
            total_reg     <= '0;
            m_valid_reg   <= 1'b0;
            status_reg    <= '0;
            oidx_reg      <= '0;
            ogen_reg      <= '0;
            alive_reg     <= 1'b0;
            all_free_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            idx_reg       <= idx_next;
            hgen_reg      <= hgen_next;
            alloc_idx_reg <= alloc_idx_next;
            occ_reg       <= occ_next;
            created_reg   <= created_next;
            total_reg     <= total_next;
            m_valid_reg   <= m_valid_next;
            status_reg    <= status_next;
            oidx_reg      <= oidx_next;
            ogen_reg      <= ogen_next;
            alive_reg     <= alive_next;
            all_free_reg  <= all_free_next;
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = ODW'({all_free_reg, alive_reg, ogen_reg, oidx_reg, status_reg});

endmodule
